// ===== rtl/axis_angle_to_rotation_matrix_core_assert.svh =====
// assertion macros for the axis-angle core
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define AA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define AA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aarm_pkg.sv =====
package aarm_pkg;

  localparam int AxisW   = 16;
  localparam int AngleW  = 27;
  localparam int EntryW  = 16;
  localparam int AxisFrac = 14;
  localparam int Steps   = 16;
  localparam int PhaseW  = 32;
  localparam int CordW   = 34;
  localparam int ZW      = 32;
  localparam int Lat     = Steps + 8;

  // 1/(2*pi) in Q48, split into a high and a low partial product
  localparam logic [21:0] InvTwoPiHi = 22'h28BE60;
  localparam logic [23:0] InvTwoPiLo = 24'hDB9391;
  // reciprocals of 45 for the degree phase
  localparam logic [25:0] DegRecip = 26'd47721859;
  localparam logic [19:0] DegFracRecip = 20'd745655;
  localparam logic signed [CordW-1:0] CordicX0 = 34'sh0_26DD_3B6A;
  localparam logic [35:0] DegTurn = 36'd23592960;

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic signed [EntryW-1:0] entry_t;
  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [ZW-1:0] zph_t;

  typedef struct packed {
    axis_t ax;
    axis_t ay;
    axis_t az;
  } axes_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    zph_t  z;
    logic [1:0] quad;
    axes_t axes;
    logic  vld;
  } cell_t;

  function automatic zph_t atan_tab(input int i);
    logic [31:0] t [0:31];
    t[0]  = 32'h20000000; t[1]  = 32'h12E4051E; t[2]  = 32'h09FB385B;
    t[3]  = 32'h051111D4; t[4]  = 32'h028B0D43; t[5]  = 32'h0145D7E1;
    t[6]  = 32'h00A2F61E; t[7]  = 32'h00517C55; t[8]  = 32'h0028BE53;
    t[9]  = 32'h00145F2F; t[10] = 32'h000A2F98; t[11] = 32'h000517CC;
    t[12] = 32'h00028BE6; t[13] = 32'h000145F3; t[14] = 32'h0000A2F9;
    t[15] = 32'h0000517D; t[16] = 32'h000028BE; t[17] = 32'h0000145F;
    t[18] = 32'h00000A30; t[19] = 32'h00000518; t[20] = 32'h0000028C;
    t[21] = 32'h00000146; t[22] = 32'h000000A3; t[23] = 32'h00000051;
    t[24] = 32'h00000029; t[25] = 32'h00000014; t[26] = 32'h0000000A;
    t[27] = 32'h00000005; t[28] = 32'h00000003; t[29] = 32'h00000001;
    t[30] = 32'h00000001; t[31] = 32'h00000000;
    return zph_t'(t[i[4:0]]);
  endfunction

endpackage

// ===== rtl/aarm_if.sv =====
interface aarm_in_if;
  import aarm_pkg::*;
  logic valid;
  logic ready;
  axis_t axis_x;
  axis_t axis_y;
  axis_t axis_z;
  logic signed [AngleW-1:0] angle;
  modport source (output valid, axis_x, axis_y, axis_z, angle, input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aarm_out_if;
  import aarm_pkg::*;
  logic valid;
  logic ready;
  entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface aarm_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/aarm_cell.sv =====
module aarm_cell
  import aarm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic [4:0] idx,
  input  cell_t d,
  output cell_t q
);
  cell_t q_r, q_nxt;
  cord_t dx, dy;
  zph_t  a;

  always_comb begin
    dx = d.y >>> idx;
    dy = d.x >>> idx;
    a  = atan_tab(int'(idx));
    q_nxt = d;
    if (!d.z[ZW-1]) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - a;
    end else begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= q_nxt.vld;
    end
    if (en) begin
      q_r.x <= q_nxt.x;
      q_r.y <= q_nxt.y;
      q_r.z <= q_nxt.z;
      q_r.quad <= q_nxt.quad;
      q_r.axes <= q_nxt.axes;
    end
  end

  assign q = q_r;
endmodule

// ===== rtl/aarm_phase.sv =====
module aarm_phase
  import aarm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic deg,
  input  logic in_vld,
  input  logic signed [AngleW-1:0] angle,
  input  axes_t axes_in,
  output cell_t q
);
  // stage 1: fold and partial products, stage 2: coarse quotient and radian sum
  // stage 3: fine quotient and unit select
  logic v1_r, v2_r, v3_r;
  logic d1_r, d2_r;
  axes_t a1_r, a2_r, a3_r;
  logic [24:0] rem_r, rem2_r;
  logic [18:0] quo_r;
  logic [31:0] ph_r;
  logic [31:0] ph2_r;
  logic signed [49:0] pk_hi_r;
  logic signed [51:0] pk_lo_r;
  logic signed [AngleW:0] r0;
  logic [26:0] rem_nxt;
  logic [50:0] quo_prod;
  logic [63:0] ph_rad;
  logic [5:0] frac_rem;
  logic [18:0] frac_num;
  logic [38:0] frac_prod;
  logic [31:0] ph_deg;

  always_comb begin
    r0 = {angle[AngleW-1], angle};
    // angle range is a few turns: fold by repeated compare
    if (r0 < 0) begin
      rem_nxt = 27'(r0 + 28'sd94371840);
      for (int k = 0; k < 3; k++) begin
        if (rem_nxt >= 27'(DegTurn)) rem_nxt = rem_nxt - 27'(DegTurn);
      end
    end else begin
      rem_nxt = 27'(r0);
      for (int k = 0; k < 3; k++) begin
        if (rem_nxt >= 27'(DegTurn)) rem_nxt = rem_nxt - 27'(DegTurn);
      end
    end
  end

  always_comb begin
    // degree phase is (rem * 2^13 + 22) / 45, split as rem = 45 * quo + frac
    quo_prod = 51'(rem_r) * 51'(DegRecip);
    ph_rad = (64'(pk_hi_r) << 24) + 64'(pk_lo_r) + 64'h8000_0000;
    frac_rem = 6'(rem2_r - 25'(quo_r) * 25'd45);
    frac_num = {frac_rem, 13'd0} + 19'd22;
    frac_prod = 39'(frac_num) * 39'(DegFracRecip);
    ph_deg = {quo_r, 13'd0} + {19'd0, frac_prod[37:25]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r;
    end
    if (en) begin
      d1_r <= deg; d2_r <= d1_r;
      a1_r <= axes_in; a2_r <= a1_r; a3_r <= a2_r;
      rem_r <= rem_nxt[24:0];
      pk_hi_r <= angle * $signed({1'b0, InvTwoPiHi});
      pk_lo_r <= angle * $signed({1'b0, InvTwoPiLo});
      ph_r <= ph_rad[63:32];
      quo_r <= quo_prod[49:31];
      rem2_r <= rem_r;
      ph2_r <= d2_r ? ph_deg : ph_r;
    end
  end

  always_comb begin
    q.vld = v3_r;
    q.axes = a3_r;
    q.quad = ph2_r[31:30];
    q.z = zph_t'({2'b00, ph2_r[29:0]});
    q.x = CordicX0;
    q.y = '0;
  end
endmodule

// ===== rtl/aarm_matrix.sv =====
module aarm_matrix
  import aarm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  cell_t d,
  output logic vld,
  output entry_t m [9]
);
  // stage a: c, s, 1-c; stage b: products ri*rj and r*s; stage c: * omc
  // stage d: sum, round, saturate
  logic va_r, vb_r, vc_r, vd_r;
  cord_t c_r, s_r, omc_r, c2_r;
  axes_t ax_r;
  logic signed [31:0] rr_r [6];
  logic signed [49:0] rs_r [3];
  logic signed [CordW-1:0] omc2_r;
  logic signed [CordW+AxisFrac-1:0] cq_r;
  logic signed [49:0] rs2_r [3];
  logic signed [65:0] t_r [6];
  entry_t m_r [9];
  cord_t c_n, s_n;
  logic signed [65:0] f [6];
  logic signed [67:0] v [9];

  function automatic entry_t rnd(input logic signed [67:0] x);
    logic signed [67:0] y;
    y = (x + (68'sd1 <<< (AxisFrac + 15))) >>> (AxisFrac + 16);
    if (y > 68'sd32767) return 16'sh7FFF;
    if (y < -68'sd32768) return 16'sh8000;
    return entry_t'(y);
  endfunction

  always_comb begin
    unique case (d.quad)
      2'd0: begin c_n = d.x;  s_n = d.y;  end
      2'd1: begin c_n = -d.y; s_n = d.x;  end
      2'd2: begin c_n = -d.x; s_n = -d.y; end
      default: begin c_n = d.y; s_n = -d.x; end
    endcase
    for (int k = 0; k < 6; k++) f[k] = 66'(rr_r[k] * omc2_r) >>> AxisFrac;
    v[0] = 68'(t_r[0]) + 68'(cq_r);
    v[4] = 68'(t_r[3]) + 68'(cq_r);
    v[8] = 68'(t_r[5]) + 68'(cq_r);
    v[1] = 68'(t_r[1]) + 68'(rs2_r[2]);
    v[3] = 68'(t_r[1]) - 68'(rs2_r[2]);
    v[2] = 68'(t_r[2]) - 68'(rs2_r[1]);
    v[6] = 68'(t_r[2]) + 68'(rs2_r[1]);
    v[5] = 68'(t_r[4]) + 68'(rs2_r[0]);
    v[7] = 68'(t_r[4]) - 68'(rs2_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0;
    end else if (en) begin
      va_r <= d.vld; vb_r <= va_r; vc_r <= vb_r; vd_r <= vc_r;
    end
    if (en) begin
      c_r <= c_n; s_r <= s_n;
      omc_r <= cord_t'(34'sd1073741824 - c_n);
      ax_r <= d.axes;
      rr_r[0] <= ax_r.ax * ax_r.ax; rr_r[1] <= ax_r.ax * ax_r.ay;
      rr_r[2] <= ax_r.ax * ax_r.az; rr_r[3] <= ax_r.ay * ax_r.ay;
      rr_r[4] <= ax_r.ay * ax_r.az; rr_r[5] <= ax_r.az * ax_r.az;
      rs_r[0] <= 50'(ax_r.ax * s_r); rs_r[1] <= 50'(ax_r.ay * s_r);
      rs_r[2] <= 50'(ax_r.az * s_r);
      omc2_r <= omc_r; c2_r <= c_r;
      for (int k = 0; k < 6; k++) t_r[k] <= f[k];
      for (int k = 0; k < 3; k++) rs2_r[k] <= rs_r[k];
      cq_r <= (CordW+AxisFrac)'(c2_r) <<< AxisFrac;
      for (int k = 0; k < 9; k++) m_r[k] <= rnd(v[k]);
    end
  end

  assign vld = vd_r;
  assign m = m_r;
endmodule

// ===== rtl/axis_angle_to_rotation_matrix_core.sv =====
// channel  dir  handshake     payload
// in       in   valid/ready   axis_x axis_y axis_z angle
// out      out  valid/ready   m00..m22
// cfg      in   valid/ready   data (angle_in_degrees)
// one item per cycle while the output is not stalled; stages: 3 phase stages + one cordic cell per step
// + 4 matrix stages + the output register
// the whole pipeline advances when the output register is empty or being taken
// synchronous active-low reset clears valids and sets degree mode
module axis_angle_to_rotation_matrix_core
  import aarm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  aarm_in_if.sink   in_ch,
  aarm_out_if.source out_ch,
  aarm_cfg_if.sink  cfg_ch
);
  `include "axis_angle_to_rotation_matrix_core_assert.svh"

  logic deg_r;
  logic en;
  logic ovld_r;
  cell_t chain [Steps+1];
  logic mvld;
  entry_t m [9];
  entry_t mo_r [9];
  axes_t axes;

  assign cfg_ch.ready = 1'b1;
  assign en = !ovld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign axes = '{ax: in_ch.axis_x, ay: in_ch.axis_y, az: in_ch.axis_z};

  always_ff @(posedge clk) begin
    if (!rst_n) deg_r <= 1'b1;
    else if (cfg_ch.valid) deg_r <= cfg_ch.data;
  end

  aarm_phase u_phase (.clk, .rst_n, .en, .deg(deg_r),
    .in_vld(in_ch.valid), .angle(in_ch.angle), .axes_in(axes), .q(chain[0]));

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    aarm_cell u_cell (.clk, .rst_n, .en, .idx(5'(g)), .d(chain[g]), .q(chain[g+1]));
  end

  aarm_matrix u_mat (.clk, .rst_n, .en, .d(chain[Steps]), .vld(mvld), .m(m));

  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (en) ovld_r <= mvld;
    if (en) mo_r <= m;
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.m00 = mo_r[0]; assign out_ch.m01 = mo_r[1];
  assign out_ch.m02 = mo_r[2]; assign out_ch.m10 = mo_r[3];
  assign out_ch.m11 = mo_r[4]; assign out_ch.m12 = mo_r[5];
  assign out_ch.m20 = mo_r[6]; assign out_ch.m21 = mo_r[7];
  assign out_ch.m22 = mo_r[8];

  `AA_ASSERT_NEXT(a_hold, clk, rst_n, ovld_r && !out_ch.ready, ovld_r && $stable(mo_r[0]), "stalled item lost")
  `AA_ASSERT_IMPL(a_rdy, clk, rst_n, !ovld_r, in_ch.ready, "ready low with empty output")
  `AA_ASSERT_NEXT(a_cfg, clk, rst_n, cfg_ch.valid, deg_r == $past(cfg_ch.data), "config not taken")
endmodule

// ===== test/aarm_rotation_checker.sv =====
module aarm_rotation_checker
  import aarm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  aarm_in_if   in_mon,
  aarm_out_if  out_mon,
  aarm_cfg_if  cfg_mon,
  output int   mismatch_count,
  output int   matrices_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [8:0][EntryW-1:0] matrix_t;

  localparam longint DegTurnQ16 = 64'd23592960;
  localparam longint unsigned InvTwoPiQ64 = 64'h28BE60DB9391054A;
  localparam longint unsigned InvTwoPiQ48 = 64'h000028BE60DB9391;

  matrix_t matrix_q[$];
  logic    unit_is_degrees;
  longint  atan_units[0:31];

  initial begin
    longint unsigned acc, term;
    int e;
    atan_units[0] = 64'sd1 << 29;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      for (int k = 0; ; k++) begin
        e = i * (2 * k + 1);
        if (e >= 64) break;
        term = (InvTwoPiQ64 >> e) / longint'(2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      atan_units[i] = longint'((acc + 64'h80000000) >> 32);
    end
  end

  function automatic logic [EntryW-1:0] mix_entry(longint ri, longint rj, longint omc,
                                                  longint extra);
    longint v;
    v = ((ri * rj * omc) >>> AxisFrac) + extra + (64'sd1 << (AxisFrac + 15));
    v = v >>> (AxisFrac + 16);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[EntryW-1:0];
  endfunction

  function automatic matrix_t predict_matrix(axis_t ax, axis_t ay, axis_t az,
                                             logic signed [AngleW-1:0] ang, logic deg);
    longint a, rem, x, y, z, dx, dy, c, s, omc, cq, cs, r0, r1, r2;
    longint unsigned wide;
    logic [31:0] phase;
    matrix_t m;
    a = ang;
    r0 = ax;
    r1 = ay;
    r2 = az;
    if (deg) begin
      rem = a % DegTurnQ16;
      if (rem < 0) rem = rem + DegTurnQ16;
      wide = ((unsigned'(rem) << 32) + unsigned'(DegTurnQ16 / 2))
             / unsigned'(DegTurnQ16);
    end else begin
      wide = (unsigned'(a) * InvTwoPiQ48 + 64'h80000000) >> 32;
    end
    phase = wide[31:0];
    z = phase[29:0];
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < Steps && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_units[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_units[i];
      end
    end
    case (phase[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    omc = (64'sd1 << 30) - c;
    cq = c * (64'sd1 << AxisFrac);
    m[0] = mix_entry(r0, r0, omc, cq);
    cs = r2 * s;
    m[1] = mix_entry(r0, r1, omc, cs);
    m[3] = mix_entry(r1, r0, omc, -cs);
    cs = r1 * s;
    m[2] = mix_entry(r0, r2, omc, -cs);
    m[6] = mix_entry(r2, r0, omc, cs);
    cs = r0 * s;
    m[5] = mix_entry(r1, r2, omc, cs);
    m[7] = mix_entry(r2, r1, omc, -cs);
    m[4] = mix_entry(r1, r1, omc, cq);
    m[8] = mix_entry(r2, r2, omc, cq);
    return m;
  endfunction

  always @(posedge clk) begin
    matrix_t seen, want;
    if (!rst_n) begin
      unit_is_degrees = 1'b1;
      matrix_q.delete();
      mismatch_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        matrix_q.push_back(predict_matrix(in_mon.axis_x, in_mon.axis_y, in_mon.axis_z,
                                          in_mon.angle, unit_is_degrees));
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.m22, out_mon.m21, out_mon.m20, out_mon.m12, out_mon.m11,
                out_mon.m10, out_mon.m02, out_mon.m01, out_mon.m00};
        if (matrix_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected item out: %h", seen);
        end else begin
          want = matrix_q.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (seen[k] !== want[k]) begin
              mismatch_count++;
              if (mismatch_count <= 10)
                $display("m%0d%0d mismatch: expected %0d got %0d", k / 3, k % 3,
                         $signed(want[k]), $signed(seen[k]));
            end
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) unit_is_degrees = cfg_mon.data;
    end
    matrices_pending = matrix_q.size();
  end
endmodule

// ===== test/tb_axis_angle_to_rotation_matrix_core.sv =====
module tb_axis_angle_to_rotation_matrix_core;
  import aarm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatch_count;
  int   matrices_pending;
  logic sender_idles = 1'b0;
  logic sink_stalls = 1'b0;
  int   hold_cycles = 0;

  aarm_in_if  in_ch();
  aarm_out_if out_ch();
  aarm_cfg_if cfg_ch();

  axis_angle_to_rotation_matrix_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  aarm_rotation_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .mismatch_count(mismatch_count), .matrices_pending(matrices_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.axis_x = '0;
    in_ch.axis_y = '0;
    in_ch.axis_z = '0;
    in_ch.angle = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(sink_stalls && $urandom_range(99) < 23);
    end
  end

  task automatic offer(axis_t ax, axis_t ay, axis_t az, logic signed [AngleW-1:0] ang);
    while (sender_idles && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.axis_x <= ax;
    in_ch.axis_y <= ay;
    in_ch.axis_z <= az;
    in_ch.angle <= ang;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (matrices_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_unit(logic deg);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= deg;
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic axis_t pick_axis();
    if ($urandom_range(9) == 0) return axis_t'($urandom);
    return axis_t'(int'($urandom_range(32768)) - 16384);
  endfunction

  task automatic random_items(int n);
    logic signed [AngleW-1:0] ang;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: ang = AngleW'($urandom);
        1: ang = AngleW'(int'($urandom_range(800 * 65536)) - 400 * 65536);
        2: ang = AngleW'(int'($urandom_range(14 * 65536)) - 7 * 65536);
        default: ang = AngleW'(int'($urandom_range(32)) * 45 * 65536 - 720 * 65536
                               + int'($urandom_range(4)) - 2);
      endcase
      offer(pick_axis(), pick_axis(), pick_axis(), ang);
    end
  endtask

  task automatic directed_items;
    offer(16384, 0, 0, 0);
    offer(0, 16384, 0, 90 * 65536);
    offer(0, 0, 16384, 180 * 65536);
    offer(16384, 16384, 16384, 270 * 65536);
    offer(-16384, 0, 0, 360 * 65536);
    offer(0, -16384, 0, -90 * 65536);
    offer(0, 0, -16384, 67108863);
    offer(32767, -32768, 32767, -67108864);
    offer(-32768, -32768, -32768, 45 * 65536);
    offer(32767, 32767, 32767, 135 * 65536);
    offer(9459, 9459, 9459, -1);
    offer(0, 0, 0, 1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    random_items(150);
    write_unit(1'b0);
    directed_items();
    offer(16384, 0, 0, 205887);
    offer(0, 16384, 0, -102944);
    offer(0, 0, 16384, 411775);
    sender_idles = 1'b1;
    sink_stalls = 1'b1;
    random_items(150);
    hold_cycles <= 200;
    random_items(60);
    drain();
    random_items(100);
    write_unit(1'b1);
    random_items(150);
    write_unit(1'b0);
    sender_idles = 1'b0;
    random_items(60);
    sender_idles = 1'b1;
    random_items(40);
    drain();
    repeat (Lat + 20) @(posedge clk);
    if (mismatch_count == 0 && matrices_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aarm_pkg.sv
rtl/aarm_if.sv
rtl/aarm_cell.sv
rtl/aarm_phase.sv
rtl/aarm_matrix.sv
rtl/axis_angle_to_rotation_matrix_core.sv
test/aarm_rotation_checker.sv
test/tb_axis_angle_to_rotation_matrix_core.sv
